// File: rtl/vvd_pkg.sv
// Shared types and constants for the voxel volume dilation block.
// Payload structs, register indexes, operation codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps
package vvd_pkg;

	localparam int DEF_MAX_X = 256;
	localparam int DEF_MAX_Y = 256;
	localparam int DEF_MAX_Z = 256;

	localparam int LABEL_W  = 8;
	localparam int COUNT_W  = 25;
	localparam int SIZE_W   = 9;
	localparam int CFG_IDX_W = 3;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X        = 3'd0,
		REG_SIZE_Y        = 3'd1,
		REG_SIZE_Z        = 3'd2,
		REG_NEIGHBOURHOOD = 3'd3,
		REG_TARGET        = 3'd4,
		REG_EMPTY         = 3'd5,
		REG_UNKNOWN       = 3'd6
	} reg_idx_t;

	localparam logic OP_VOXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;
	localparam logic NBH_CUBE = 1'b0;
	localparam logic NBH_FACE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [LABEL_W-1:0] voxel_label;
	} item_t;

	typedef struct packed {
		logic [LABEL_W-1:0] out_label;
		logic               last_voxel;
		logic [COUNT_W-1:0] dilated_count;
	} result_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               emit;
	} qent_t;

	typedef struct packed {
		logic               nbh;
		logic [LABEL_W-1:0] target;
		logic [LABEL_W-1:0] empty;
		logic [LABEL_W-1:0] unknown;
	} lbl_cfg_t;

endpackage

// File: rtl/vvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read of an address being written returns the old contents.
// No dependencies.
`timescale 1ns / 1ps
module vvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/vvd_fifo.sv
// Small register FIFO used for the work queue and the result queue.
// Depth must be a power of two. No dependencies.
`timescale 1ns / 1ps
module vvd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             nonempty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/vvd_front.sv
// Front end: accepts input beats, drops early drains, adds fill beats for short
// volumes and tags each window push with whether it yields a result.
// Depends on vvd_pkg.
`timescale 1ns / 1ps
module vvd_front #(
	parameter int KW = 41,
	parameter int DW = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic               hold,
	input  logic               push,
	output logic               full,
	input  vvd_pkg::item_t     item,
	input  logic [KW-1:0]      total,
	input  logic [DW-1:0]      delay,
	input  logic [KW-1:0]      end_cnt,
	output logic               q_wr,
	output vvd_pkg::qent_t     q_data,
	input  logic               q_full
);

	logic [KW-1:0] kin_q, kin_nx, delay_k;
	logic          fill_q, filling, acc, in_vol;

	always_comb begin
		delay_k = KW'(delay);
		kin_nx  = kin_q + 1'b1;
		in_vol  = (kin_q < total);
		filling = fill_q && !q_full;
		full    = q_full || fill_q || hold;
		acc     = push && !full;
		q_wr    = 1'b0;
		q_data  = '0;
		if (filling) begin
			q_wr        = 1'b1;
			q_data.emit = (kin_q == delay_k);
		end else if (acc) begin
			if (in_vol) begin
				if (item.operation == vvd_pkg::OP_VOXEL) begin
					q_wr         = 1'b1;
					q_data.label = item.voxel_label;
					q_data.emit  = (kin_q >= delay_k);
				end
			end else begin
				q_wr        = 1'b1;
				q_data.emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kin_q  <= '0;
			fill_q <= 1'b0;
		end else if (restart) begin
			kin_q  <= '0;
			fill_q <= 1'b0;
		end else if (q_wr) begin
			kin_q <= (kin_nx == end_cnt) ? '0 : kin_nx;
			if (filling && q_data.emit) begin
				fill_q <= 1'b0;
			end
			if (!filling && in_vol && kin_nx == total && total <= delay_k) begin
				fill_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/vvd_back.sv
// Back end: 3x3x3 window built from plane and row delay lines, neighbour test,
// conversion count and result queue. Depends on vvd_pkg, vvd_ram, vvd_fifo.
`timescale 1ns / 1ps
module vvd_back #(
	parameter int MAX_X = vvd_pkg::DEF_MAX_X,
	parameter int MAX_Y = vvd_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vvd_pkg::DEF_MAX_Z
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    restart,
	input  vvd_pkg::lbl_cfg_t                       lcfg,
	input  logic [$clog2(MAX_X+1)-1:0]              sx,
	input  logic [$clog2(MAX_Y+1)-1:0]              sy,
	input  logic [$clog2(MAX_Z+1)-1:0]              sz,
	input  logic [$clog2(MAX_X+1)-1:0]              row_last,
	input  logic [$clog2(MAX_X*MAX_Y+1)-1:0]        plane_last,
	input  logic                                    q_valid,
	input  vvd_pkg::qent_t                          q_data,
	output logic                                    q_rd,
	input  logic                                    pop,
	output logic                                    empty,
	output vvd_pkg::result_t                        result
);

	localparam int LW   = vvd_pkg::LABEL_W;
	localparam int XW   = $clog2(MAX_X + 1);
	localparam int YW   = $clog2(MAX_Y + 1);
	localparam int ZW   = $clog2(MAX_Z + 1);
	localparam int PD   = MAX_X * MAX_Y;
	localparam int RAW  = $clog2(MAX_X);
	localparam int PAW  = $clog2(PD);
	localparam int CXW  = $clog2(MAX_X);
	localparam int CYW  = $clog2(MAX_Y);
	localparam int CZW  = $clog2(MAX_Z);
	localparam int RESW = $bits(vvd_pkg::result_t);

	logic [LW-1:0]  str [3][3];
	logic [LW-1:0]  tap_q [3][3][3];
	logic [LW-1:0]  s00_q;
	logic [RAW-1:0] row_ptr_q;
	logic [PAW-1:0] plane_ptr_q;
	logic           row_byp, plane_byp;
	logic           emit_s1, go, o_wr, o_full, o_nonempty;
	logic [CXW-1:0] px_q;
	logic [CYW-1:0] py_q;
	logic [CZW-1:0] pz_q;
	logic [vvd_pkg::COUNT_W-1:0] cnt_q, cnt_nx;
	logic           conv, hit, last, xin, yin, zin, nok;
	logic [1:0]     span;
	logic [LW-1:0]  lab;
	vvd_pkg::result_t o_data;
	logic [RESW-1:0]  o_rdata;

	assign row_byp   = (sx == XW'(1));
	assign plane_byp = (sx == XW'(1)) && (sy == YW'(1));
	assign go        = !emit_s1 || !o_full;
	assign q_rd      = q_valid && go;
	assign o_wr      = emit_s1 && !o_full;
	assign str[0][0] = s00_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			s00_q <= q_data.label;
		end
	end

	// plane delay lines feed the first row of each deeper plane
	for (genvar c = 1; c < 3; c++) begin : g_plane
		logic [LW-1:0] rd, byp_q;
		vvd_ram #(.WIDTH(LW), .DEPTH(PD)) u_ram (
			.clk  (clk),
			.we   (q_rd),
			.waddr(plane_ptr_q),
			.wdata(str[c-1][0]),
			.re   (q_rd),
			.raddr(plane_ptr_q),
			.rdata(rd)
		);
		always_ff @(posedge clk) begin
			if (q_rd) begin
				byp_q <= str[c-1][0];
			end
		end
		assign str[c][0] = plane_byp ? byp_q : rd;
	end

	for (genvar c = 0; c < 3; c++) begin : g_rowc
		for (genvar b = 1; b < 3; b++) begin : g_row
			logic [LW-1:0] rd, byp_q;
			vvd_ram #(.WIDTH(LW), .DEPTH(MAX_X)) u_ram (
				.clk  (clk),
				.we   (q_rd),
				.waddr(row_ptr_q),
				.wdata(str[c][b-1]),
				.re   (q_rd),
				.raddr(row_ptr_q),
				.rdata(rd)
			);
			always_ff @(posedge clk) begin
				if (q_rd) begin
					byp_q <= str[c][b-1];
				end
			end
			assign str[c][b] = row_byp ? byp_q : rd;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_tc
		for (genvar b = 0; b < 3; b++) begin : g_tb
			logic [LW-1:0] t1_q, t2_q;
			always_ff @(posedge clk) begin
				if (q_rd) begin
					t1_q <= str[c][b];
					t2_q <= t1_q;
				end
			end
			assign tap_q[c][b][0] = str[c][b];
			assign tap_q[c][b][1] = t1_q;
			assign tap_q[c][b][2] = t2_q;
		end
	end

	always_comb begin
		lab  = tap_q[1][1][1];
		hit  = 1'b0;
		xin  = 1'b0;
		yin  = 1'b0;
		zin  = 1'b0;
		nok  = 1'b0;
		span = '0;
		for (int c = 0; c < 3; c++) begin
			for (int b = 0; b < 3; b++) begin
				for (int a = 0; a < 3; a++) begin
					span = 2'((a != 1) + (b != 1) + (c != 1));
					nok  = (span != 2'd0) &&
						(lcfg.nbh == vvd_pkg::NBH_CUBE || span == 2'd1);
					xin  = (a == 1) || (a == 0 && XW'(px_q) != sx - 1'b1) ||
						(a == 2 && px_q != '0);
					yin  = (b == 1) || (b == 0 && YW'(py_q) != sy - 1'b1) ||
						(b == 2 && py_q != '0);
					zin  = (c == 1) || (c == 0 && ZW'(pz_q) != sz - 1'b1) ||
						(c == 2 && pz_q != '0);
					if (nok && xin && yin && zin && tap_q[c][b][a] == lcfg.target) begin
						hit = 1'b1;
					end
				end
			end
		end
		conv = (lab == lcfg.unknown) || (lab == lcfg.empty && hit);
		last = (XW'(px_q) == sx - 1'b1) && (YW'(py_q) == sy - 1'b1) &&
			(ZW'(pz_q) == sz - 1'b1);
		cnt_nx = (conv && cnt_q != vvd_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		o_data.out_label     = conv ? lcfg.target : lab;
		o_data.last_voxel    = last;
		o_data.dilated_count = cnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1     <= 1'b0;
			row_ptr_q   <= '0;
			plane_ptr_q <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			cnt_q       <= '0;
		end else if (restart) begin
			emit_s1     <= 1'b0;
			row_ptr_q   <= '0;
			plane_ptr_q <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (go) begin
				emit_s1 <= q_rd && q_data.emit;
			end
			if (q_rd) begin
				row_ptr_q   <= (row_ptr_q == RAW'(row_last)) ? '0 : row_ptr_q + 1'b1;
				plane_ptr_q <= (plane_ptr_q == PAW'(plane_last)) ? '0 :
					plane_ptr_q + 1'b1;
			end
			if (o_wr) begin
				if (last) begin
					px_q  <= '0;
					py_q  <= '0;
					pz_q  <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_nx;
					if (XW'(px_q) != sx - 1'b1) begin
						px_q <= px_q + 1'b1;
					end else begin
						px_q <= '0;
						if (YW'(py_q) != sy - 1'b1) begin
							py_q <= py_q + 1'b1;
						end else begin
							py_q <= '0;
							pz_q <= pz_q + 1'b1;
						end
					end
				end
			end
		end
	end

	vvd_fifo #(.WIDTH(RESW), .DEPTH(2)) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (o_wr),
		.wdata   (o_data),
		.rd      (pop && o_nonempty),
		.rdata   (o_rdata),
		.full    (o_full),
		.nonempty(o_nonempty)
	);

	assign empty  = !o_nonempty;
	assign result = o_rdata;

`ifndef SYNTHESIS
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		o_wr |-> !o_full) else $error("result queue overflow");
	a_hold_win: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s1 && o_full) |=> (emit_s1 && $stable(s00_q)))
		else $error("window moved while result stalled");
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(o_wr && last) |=> (px_q == '0 && py_q == '0 && pz_q == '0 && cnt_q == '0))
		else $error("volume did not wrap after last voxel");
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(o_wr && !last && !restart) |=> (cnt_q >= $past(cnt_q)))
		else $error("conversion count decreased");
`endif

endmodule

// File: rtl/voxel_volume_dilation.sv
// Top level of the voxel volume dilation block: configuration registers,
// volume geometry, front end, work queue and back end.
// Depends on vvd_pkg, vvd_front, vvd_fifo, vvd_back.
//
// Usage: voxels enter in raster order on item while full is low (push), and
// dilated voxels leave in the same order on result while empty is low (pop).
// A result for voxel p leaves after voxel p + size_x*size_y + size_x + 1 has
// entered; after the last voxel, drain beats push out the remaining ones.
// Drain beats sent before the volume is complete are dropped. When the whole
// volume is shorter than that window, the block inserts its own fill beats
// after the last voxel and holds full high while it inserts them.
// Throughput is one beat per cycle while full is low; the result that a beat
// releases goes through the work queue, the emit register and the result
// queue to the result ports. The 3x3x3 window comes from two plane delay
// memories and six row delay memories, one push a cycle unless stalled.
// Configuration writes are taken at any time (cfg_ready is always high) and
// are expected only while no results are pending. Writing a size register
// restarts the volume and holds full high while the volume geometry is
// recomputed. Reset clears the positions and count and loads the default
// registers. A stalled receiver fills the two-entry result queue, then the
// four-entry work queue, then full rises.
`timescale 1ns / 1ps
module voxel_volume_dilation #(
	parameter int MAX_X = vvd_pkg::DEF_MAX_X,
	parameter int MAX_Y = vvd_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vvd_pkg::DEF_MAX_Z
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  vvd_pkg::item_t                       item,
	input  logic                                 pop,
	output logic                                 empty,
	output vvd_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vvd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vvd_pkg::SIZE_W-1:0]           cfg_data
);

	localparam int XW = $clog2(MAX_X + 1);
	localparam int YW = $clog2(MAX_Y + 1);
	localparam int ZW = $clog2(MAX_Z + 1);
	localparam longint PLANE_MAX = longint'(MAX_X) * longint'(MAX_Y);
	localparam longint TOT_MAX   = PLANE_MAX * longint'(MAX_Z);
	localparam longint D_MAX     = PLANE_MAX + longint'(MAX_X) + 1;
	localparam int PW = $clog2(PLANE_MAX + 1);
	localparam int DW = $clog2(D_MAX + 1);
	localparam int KW = $clog2(TOT_MAX + D_MAX + 1);
	localparam int LW = vvd_pkg::LABEL_W;
	localparam int SW = vvd_pkg::SIZE_W;
	localparam int QW = $bits(vvd_pkg::qent_t);

	logic [SW-1:0]   size_x_q, size_y_q, size_z_q;
	logic            nbh_q;
	logic [LW-1:0]   target_q, empty_q, unknown_q;
	logic [XW-1:0]   sx;
	logic [YW-1:0]   sy;
	logic [ZW-1:0]   sz;
	logic [PW-1:0]   plane_q, plane_last_q;
	logic [DW-1:0]   delay_q;
	logic [KW-1:0]   total_q, end_q;
	logic [XW-1:0]   row_last_q;
	logic [1:0]      settle_q;
	logic            cfg_wr, restart;
	vvd_pkg::lbl_cfg_t lcfg;
	vvd_pkg::qent_t  fq_data, bq_data;
	logic            fq_wr, q_full, q_nonempty, q_rd;
	logic [QW-1:0]   bq_raw;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == vvd_pkg::REG_SIZE_X ||
		cfg_index == vvd_pkg::REG_SIZE_Y || cfg_index == vvd_pkg::REG_SIZE_Z);

	assign sx = (size_x_q == '0) ? XW'(1) :
		(32'(size_x_q) > MAX_X) ? XW'(MAX_X) : XW'(size_x_q);
	assign sy = (size_y_q == '0) ? YW'(1) :
		(32'(size_y_q) > MAX_Y) ? YW'(MAX_Y) : YW'(size_y_q);
	assign sz = (size_z_q == '0) ? ZW'(1) :
		(32'(size_z_q) > MAX_Z) ? ZW'(MAX_Z) : ZW'(size_z_q);

	assign lcfg.nbh     = nbh_q;
	assign lcfg.target  = target_q;
	assign lcfg.empty   = empty_q;
	assign lcfg.unknown = unknown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= SW'(256);
			size_y_q  <= SW'(256);
			size_z_q  <= SW'(256);
			nbh_q     <= vvd_pkg::NBH_CUBE;
			target_q  <= LW'(1);
			empty_q   <= '0;
			unknown_q <= '1;
			settle_q  <= 2'd3;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					vvd_pkg::REG_SIZE_X:        size_x_q  <= cfg_data;
					vvd_pkg::REG_SIZE_Y:        size_y_q  <= cfg_data;
					vvd_pkg::REG_SIZE_Z:        size_z_q  <= cfg_data;
					vvd_pkg::REG_NEIGHBOURHOOD: nbh_q     <= cfg_data[0];
					vvd_pkg::REG_TARGET:        target_q  <= cfg_data[LW-1:0];
					vvd_pkg::REG_EMPTY:         empty_q   <= cfg_data[LW-1:0];
					vvd_pkg::REG_UNKNOWN:       unknown_q <= cfg_data[LW-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				settle_q <= 2'd3;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	// geometry, at most one multiply per stage
	always_ff @(posedge clk) begin
		plane_q      <= PW'(sx * sy);
		row_last_q   <= sx - XW'(2);
		plane_last_q <= plane_q - PW'(2);
		delay_q      <= DW'(plane_q) + DW'(sx) + DW'(1);
		total_q      <= KW'(plane_q * sz);
		end_q        <= total_q + KW'(delay_q);
	end

	vvd_front #(.KW(KW), .DW(DW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(restart),
		.hold   (settle_q != 2'd0),
		.push   (push),
		.full   (full),
		.item   (item),
		.total  (total_q),
		.delay  (delay_q),
		.end_cnt(end_q),
		.q_wr   (fq_wr),
		.q_data (fq_data),
		.q_full (q_full)
	);

	vvd_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_wr),
		.wdata   (fq_data),
		.rd      (q_rd),
		.rdata   (bq_raw),
		.full    (q_full),
		.nonempty(q_nonempty)
	);

	assign bq_data = bq_raw;

	vvd_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.lcfg      (lcfg),
		.sx        (sx),
		.sy        (sy),
		.sz        (sz),
		.row_last  (row_last_q),
		.plane_last(plane_last_q),
		.q_valid   (q_nonempty),
		.q_data    (bq_data),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: test/tb.sv
// Testbench for voxel_volume_dilation: streams small labelled volumes with
// random sizes and label settings, and predicts each dilated voxel in a class.
// Depends on vvd_pkg and the voxel_volume_dilation RTL.
`timescale 1ns / 1ps
module tb;

	class dilation_scoreboard;
		logic [vvd_pkg::SIZE_W-1:0] size_x = 9'd256, size_y = 9'd256, size_z = 9'd256;
		logic nbh = vvd_pkg::NBH_CUBE;
		logic [vvd_pkg::LABEL_W-1:0] target = 8'd1, empty_lbl = 8'd0, unknown = 8'd255;
		logic [vvd_pkg::LABEL_W-1:0] labels [int];
		int in_pos, out_pos;
		logic [vvd_pkg::COUNT_W-1:0] converted;
		vvd_pkg::result_t expected_q [$];
		int errors, checked;

		function int clamp(logic [vvd_pkg::SIZE_W-1:0] v);
			if (v == 0) return 1;
			if (v > vvd_pkg::DEF_MAX_X) return vvd_pkg::DEF_MAX_X;
			return int'(v);
		endfunction

		function void restart();
			in_pos = 0;
			out_pos = 0;
			converted = 0;
			labels.delete();
		endfunction

		function void set_reg(vvd_pkg::reg_idx_t idx, logic [vvd_pkg::SIZE_W-1:0] data);
			case (idx)
				vvd_pkg::REG_SIZE_X: begin size_x = data; restart(); end
				vvd_pkg::REG_SIZE_Y: begin size_y = data; restart(); end
				vvd_pkg::REG_SIZE_Z: begin size_z = data; restart(); end
				vvd_pkg::REG_NEIGHBOURHOOD: nbh = data[0];
				vvd_pkg::REG_TARGET: target = data[vvd_pkg::LABEL_W-1:0];
				vvd_pkg::REG_EMPTY: empty_lbl = data[vvd_pkg::LABEL_W-1:0];
				vvd_pkg::REG_UNKNOWN: unknown = data[vvd_pkg::LABEL_W-1:0];
				default: ;
			endcase
		endfunction

		function int total();
			return clamp(size_x) * clamp(size_y) * clamp(size_z);
		endfunction

		// returns 1 when the beat was taken into the volume or emitted a voxel
		function bit note(vvd_pkg::item_t it);
			int sx, sy, sz, tot, dly, px, py, pz, nx, ny, nz, span;
			logic [vvd_pkg::LABEL_W-1:0] lbl;
			bit conv;
			vvd_pkg::result_t r;
			sx = clamp(size_x);
			sy = clamp(size_y);
			sz = clamp(size_z);
			tot = sx * sy * sz;
			dly = sx * sy + sx + 1;
			conv = 0;
			if (in_pos < tot) begin
				if (it.operation == vvd_pkg::OP_DRAIN)
					return 0;
				labels[in_pos] = it.voxel_label;
				in_pos++;
			end
			if (in_pos < tot && in_pos <= out_pos + dly)
				return 1;
			px = out_pos % sx;
			py = (out_pos / sx) % sy;
			pz = out_pos / (sx * sy);
			lbl = labels[out_pos];
			if (lbl == unknown)
				conv = 1;
			else if (lbl == empty_lbl) begin
				for (int dz = -1; dz <= 1; dz++)
					for (int dy = -1; dy <= 1; dy++)
						for (int dx = -1; dx <= 1; dx++) begin
							span = (dx != 0) + (dy != 0) + (dz != 0);
							nx = px + dx;
							ny = py + dy;
							nz = pz + dz;
							if (span == 0 || (nbh == vvd_pkg::NBH_FACE && span != 1))
								continue;
							if (nx < 0 || ny < 0 || nz < 0 || nx >= sx || ny >= sy || nz >= sz)
								continue;
							if (labels[nx + ny * sx + nz * sx * sy] == target)
								conv = 1;
						end
			end
			if (conv && converted != vvd_pkg::COUNT_MAX)
				converted++;
			r.out_label = conv ? target : lbl;
			r.last_voxel = (out_pos + 1 == tot);
			r.dilated_count = converted;
			expected_q.push_back(r);
			out_pos++;
			if (out_pos >= tot)
				restart();
			return 1;
		endfunction

		function void check(vvd_pkg::result_t got);
			vvd_pkg::result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (got.out_label !== exp_r.out_label) begin
				$display("%0t: out_label expected %0d got %0d", $time,
					exp_r.out_label, got.out_label);
				errors++;
			end
			if (got.last_voxel !== exp_r.last_voxel) begin
				$display("%0t: last_voxel expected %0d got %0d", $time,
					exp_r.last_voxel, got.last_voxel);
				errors++;
			end
			if (got.dilated_count !== exp_r.dilated_count) begin
				$display("%0t: dilated_count expected %0d got %0d", $time,
					exp_r.dilated_count, got.dilated_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full, empty, cfg_ready;
	vvd_pkg::item_t item = '0;
	logic pop = 0;
	vvd_pkg::result_t result;
	logic cfg_valid = 0;
	logic [vvd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vvd_pkg::SIZE_W-1:0] cfg_data = '0;

	dilation_scoreboard sb = new();
	int send_idle, recv_idle, hold_left, beats_in, volumes;

	voxel_volume_dilation dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (pop && !empty)
			sb.check(result);
		if (hold_left > 0) begin
			pop <= 0;
			hold_left--;
		end else
			pop <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_beat(vvd_pkg::item_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		item <= it;
		do @(posedge clk); while (full);
		if (sb.note(it))
			beats_in++;
	endtask

	task automatic wait_drained();
		push <= 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(vvd_pkg::reg_idx_t idx, logic [vvd_pkg::SIZE_W-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	function automatic logic [vvd_pkg::LABEL_W-1:0] pick_label();
		int r;
		r = $urandom_range(99);
		if (r < 30) return sb.target;
		if (r < 65) return sb.empty_lbl;
		if (r < 75) return sb.unknown;
		return 8'($urandom_range(255));
	endfunction

	task automatic run_volume(bit directed);
		vvd_pkg::item_t it;
		int tot;
		tot = sb.total();
		for (int k = 0; k < tot; k++) begin
			if (!directed && $urandom_range(99) < 8) begin
				it.operation = vvd_pkg::OP_DRAIN;
				it.voxel_label = 8'($urandom_range(255));
				send_beat(it);
			end
			it.operation = vvd_pkg::OP_VOXEL;
			if (directed)
				it.voxel_label = (k == tot / 2) ? sb.target :
					(k == 0) ? sb.unknown : sb.empty_lbl;
			else
				it.voxel_label = pick_label();
			send_beat(it);
		end
		while (sb.in_pos != 0) begin
			it.operation = ($urandom_range(99) < 20) ? vvd_pkg::OP_VOXEL : vvd_pkg::OP_DRAIN;
			it.voxel_label = 8'($urandom_range(255));
			send_beat(it);
		end
		volumes++;
		wait_drained();
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic set_geometry(int x, int y, int z);
		write_reg(vvd_pkg::REG_SIZE_X, 9'(x));
		write_reg(vvd_pkg::REG_SIZE_Y, 9'(y));
		write_reg(vvd_pkg::REG_SIZE_Z, 9'(z));
	endtask

	task automatic random_setup();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			set_geometry($urandom_range(1) ? 256 : 511, 1, 1);
		else if (r < 8)
			set_geometry(1, 256, 1);
		else if (r < 12)
			set_geometry(1, 1, $urandom_range(1) ? 256 : 511);
		else
			set_geometry($urandom_range(5), $urandom_range(5), $urandom_range(4));
		if ($urandom_range(1))
			write_reg(vvd_pkg::REG_NEIGHBOURHOOD,
				{8'($urandom_range(255)), 1'($urandom_range(1))});
		if ($urandom_range(3) == 0)
			write_reg(vvd_pkg::REG_TARGET, 9'($urandom_range(511)));
		if ($urandom_range(3) == 0)
			write_reg(vvd_pkg::REG_EMPTY,
				$urandom_range(1) ? 9'(sb.target) : 9'($urandom_range(511)));
		if ($urandom_range(3) == 0)
			write_reg(vvd_pkg::REG_UNKNOWN,
				$urandom_range(3) ? 9'($urandom_range(511)) : 9'(sb.empty_lbl));
		cfg_valid <= 0;
	endtask

	initial begin
		vvd_pkg::item_t it;
		send_idle = 0;
		recv_idle = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// default geometry is far too big to finish; a few beats then restart
		it = '{vvd_pkg::OP_VOXEL, 8'hFF};
		send_beat(it);
		it = '{vvd_pkg::OP_DRAIN, 8'h00};
		send_beat(it);
		it = '{vvd_pkg::OP_VOXEL, 8'h00};
		send_beat(it);
		wait_drained();

		set_geometry(3, 3, 3);
		write_reg(vvd_pkg::REG_NEIGHBOURHOOD, 9'(vvd_pkg::NBH_CUBE));
		write_reg(vvd_pkg::REG_TARGET, 9'd255);
		write_reg(vvd_pkg::REG_EMPTY, 9'd0);
		write_reg(vvd_pkg::REG_UNKNOWN, 9'd7);
		cfg_valid <= 0;
		run_volume(1);
		write_reg(vvd_pkg::REG_NEIGHBOURHOOD, 9'(vvd_pkg::NBH_FACE));
		cfg_valid <= 0;
		run_volume(1);
		set_geometry(0, 1, 1);
		cfg_valid <= 0;
		run_volume(1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 35 : (phase == 1) ? 74 : 0;
			recv_idle = (phase == 0) ? 74 : (phase == 1) ? 35 : 0;
			if (phase == 2) begin
				set_geometry(4, 4, 4);
				cfg_valid <= 0;
				hold_left = 300;
				run_volume(0);
			end
			while (beats_in < 550 * (phase + 1)) begin
				random_setup();
				run_volume(0);
			end
		end

		wait_drained();
		$display("%0d volumes, %0d input beats, %0d results checked, %0d mismatches",
			volumes, beats_in, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
